### hw/rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// Priority ready queue package
// Shared entry type, command and status codes, and per-cell control.
// ----------------------------------------------------------------------------
package prq_pkg;

  // Fixed field widths of one item.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned DEADLINE_W = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned STATUS_W   = 2;

  // Command codes. Any other code behaves as a query.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // One stored task entry.
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [PRIO_W-1:0]     prio;
    logic [PRIO_W-1:0]     ceil;
    logic                  elev;
    logic [DEADLINE_W-1:0] deadline;
  } prq_entry_t;

  // Operation that every cell of the chain applies in the same cycle.
  typedef struct packed {
    logic insert;
    logic remove;
  } prq_ctl_t;

endpackage

### hw/rtl/prq_cell.sv
// ----------------------------------------------------------------------------
// Priority ready queue cell
// Holds one queue slot, tests it against the operation's item, and shifts
// toward the tail on insert or toward the head on remove.
// ----------------------------------------------------------------------------
module prq_cell
  import prq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  prq_ctl_t   ctl,
  input  prq_entry_t new_entry,
  input  prq_entry_t prev_entry,
  input  logic       prev_valid,
  input  prq_entry_t next_entry,
  input  logic       next_valid,
  input  logic       found_in,
  output logic       found_out,
  output prq_entry_t entry,
  output logic       valid
);

  logic goes_before;
  logic hit;

  // Ordering test: the new item goes in front of this slot.
  always_comb begin
    goes_before = (entry.elev && (entry.ceil < new_entry.prio))
               || (new_entry.elev && (entry.prio < new_entry.ceil))
               || (entry.prio < new_entry.prio)
               || (new_entry.deadline < entry.deadline);
  end

  // An empty slot always takes an insert; a remove needs a matching id.
  always_comb begin
    if (ctl.insert) begin
      hit = !valid || goes_before;
    end else if (ctl.remove) begin
      hit = valid && (entry.id == new_entry.id);
    end else begin
      hit = 1'b0;
    end
  end

  // The first hit along the chain marks the insert or removal point.
  assign found_out = found_in || hit;

  // Valid flag of the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.insert) begin
      if (found_in) begin
        valid <= prev_valid;
      end else if (hit) begin
        valid <= 1'b1;
      end
    end else if (ctl.remove && found_out) begin
      valid <= next_valid;
    end
  end

  // Stored entry; no reset needed.
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (found_in) begin
        entry <= prev_entry;
      end else if (hit) begin
        entry <= new_entry;
      end
    end else if (ctl.remove && found_out) begin
      entry <= next_entry;
    end
  end

endmodule

### hw/rtl/priority_ready_queue_top.sv
// ----------------------------------------------------------------------------
// Priority ready queue top level
// Ordered task queue built from a row of slot cells.
// ----------------------------------------------------------------------------
// Each item goes through these steps from acceptance to its result: the
// command is captured, every cell tests its slot in parallel and the whole
// row shifts at once along the hit chain, and the new head is presented.
// The input is ready again once the result is in the output register, so
// the queue takes no new item before the last one has its result. The queue
// is empty after reset; entries are ordered by the ceiling, priority and
// deadline tests, an insert into a full queue is dropped with status 1, and
// a remove of an id not present gives status 2.
// ----------------------------------------------------------------------------
module priority_ready_queue_top
  import prq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [ID_W-1:0]       task_id,
  input  logic [PRIO_W-1:0]     priority_req,
  input  logic [PRIO_W-1:0]     ceiling,
  input  logic                  elevated,
  input  logic [DEADLINE_W-1:0] deadline,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       head_task_id,
  output logic                  head_valid,
  output logic [COUNT_W-1:0]    entry_count,
  output logic [STATUS_W-1:0]   status
);

  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [CMD_W-1:0]      op_cmd;
  prq_entry_t            op_entry;
  logic [CNT_W-1:0]      count;
  logic [STATUS_W-1:0]   op_status;
  prq_ctl_t              ctl;
  logic                  full;

  prq_entry_t            cell_entry [MAX_TASKS];
  logic [MAX_TASKS-1:0]  cell_valid;
  logic [MAX_TASKS:0]    found;

  assign in_ready = (state == S_IDLE);
  assign full     = (count == CNT_W'(MAX_TASKS));

  // Control sequence.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_cmd            <= command;
      op_entry.id       <= task_id;
      op_entry.prio     <= priority_req;
      op_entry.ceil     <= ceiling;
      op_entry.elev     <= elevated;
      op_entry.deadline <= deadline;
    end
  end

  // Operation broadcast to the cells; a full queue ignores inserts.
  always_comb begin
    ctl.insert = (state == S_EXEC) && (op_cmd == CMD_INSERT) && !full;
    ctl.remove = (state == S_EXEC) && (op_cmd == CMD_REMOVE);
  end

  // Row of slot cells linked by the hit chain.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    prq_entry_t p_entry, n_entry;
    logic       p_valid, n_valid;

    if (i == 0) begin : g_first
      assign p_entry = op_entry;
      assign p_valid = 1'b0;
    end else begin : g_mid
      assign p_entry = cell_entry[i-1];
      assign p_valid = cell_valid[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_last
      assign n_entry = op_entry;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_entry = cell_entry[i+1];
      assign n_valid = cell_valid[i+1];
    end

    prq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_entry  (op_entry),
      .prev_entry (p_entry),
      .prev_valid (p_valid),
      .next_entry (n_entry),
      .next_valid (n_valid),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .entry      (cell_entry[i]),
      .valid      (cell_valid[i])
    );
  end

  // Entry count and status of the operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      op_status <= STATUS_OK;
    end else if (state == S_EXEC) begin
      op_status <= STATUS_OK;
      case (op_cmd)
        CMD_INSERT: begin
          if (full) begin
            op_status <= STATUS_FULL;
          end else begin
            count <= count + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (found[MAX_TASKS]) begin
            count <= count - CNT_W'(1);
          end else begin
            op_status <= STATUS_NOT_FOUND;
          end
        end
        default: begin
          op_status <= STATUS_OK;
        end
      endcase
    end
  end

  // Result register, loaded once the row has settled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_REPORT) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_REPORT) && (!out_valid || out_ready)) begin
      head_task_id <= cell_valid[0] ? cell_entry[0].id : '0;
      head_valid   <= cell_valid[0];
      entry_count  <= COUNT_W'(count);
      status       <= op_status;
    end
  end

endmodule

### hw/rtl/prq_checker.sv
// ----------------------------------------------------------------------------
// Priority ready queue checker
// Port-level checks on the results of the queue.
// ----------------------------------------------------------------------------
module prq_checker
  import prq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [CMD_W-1:0]      command,
  input logic [ID_W-1:0]       task_id,
  input logic [PRIO_W-1:0]     priority_req,
  input logic [PRIO_W-1:0]     ceiling,
  input logic                  elevated,
  input logic [DEADLINE_W-1:0] deadline,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ID_W-1:0]       head_task_id,
  input logic                  head_valid,
  input logic [COUNT_W-1:0]    entry_count,
  input logic [STATUS_W-1:0]   status
);

  // A waiting input item keeps its valid and its fields.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(command) && $stable(task_id)
      && $stable(priority_req) && $stable(ceiling) && $stable(elevated)
      && $stable(deadline))
    else $error("input item changed while waiting");

  // A stalled result item holds its head id and status.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(head_task_id) && $stable(status))
    else $error("result item changed while stalled");

  // An empty queue reports id zero.
  a_empty_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> head_task_id == '0)
    else $error("empty queue reports a nonzero head id");

  // An empty queue reports a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> entry_count == '0)
    else $error("empty queue reports a nonzero count");

  // A dropped insert means the queue holds its full number of entries.
  a_full_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_FULL) |->
      head_valid && (entry_count == COUNT_W'(MAX_TASKS)))
    else $error("full status without a full queue");

endmodule

bind priority_ready_queue_top prq_checker #(.MAX_TASKS(MAX_TASKS)) u_prq_checker (.*);

### verif/priority_ready_queue_top_tb.sv
// ----------------------------------------------------------------------------
// Priority ready queue testbench
// Drives insert, remove and query items through the valid/ready input,
// predicts the head, count and status of every result with a software copy
// of the ordered queue, and checks each result in order.
// ----------------------------------------------------------------------------

// Scoreboard: ordered copy of the task queue plus the results still owed.
class prq_scoreboard #(int unsigned DEPTH = 16);

  typedef struct {
    logic [prq_pkg::ID_W-1:0]     head_id;
    logic                         head_valid;
    logic [prq_pkg::COUNT_W-1:0]  count;
    logic [prq_pkg::STATUS_W-1:0] status;
  } head_report_t;

  prq_pkg::prq_entry_t slots[DEPTH];
  int unsigned         depth;
  head_report_t        owed_q[$];

  int unsigned errors;
  int unsigned results_seen;
  int unsigned inserts, drops, removes, misses, queries, peak_depth;

  function new();
    depth = 0;
    errors = 0;
    results_seen = 0;
    inserts = 0;
    drops = 0;
    removes = 0;
    misses = 0;
    queries = 0;
    peak_depth = 0;
  endfunction

  // True when the new task must stand in front of the stored entry.
  function bit ranks_ahead(prq_pkg::prq_entry_t nw, prq_pkg::prq_entry_t e);
    return (e.elev && (e.ceil < nw.prio)) ||
           (nw.elev && (e.prio < nw.ceil)) ||
           (e.prio < nw.prio) ||
           (nw.deadline < e.deadline);
  endfunction

  function logic [prq_pkg::STATUS_W-1:0] insert_task(prq_pkg::prq_entry_t nw);
    int unsigned pos;
    pos = 0;
    if (depth >= DEPTH) return prq_pkg::STATUS_FULL;
    while (pos < depth && !ranks_ahead(nw, slots[pos])) pos++;
    for (int unsigned k = depth; k > pos; k--) slots[k] = slots[k-1];
    slots[pos] = nw;
    depth++;
    return prq_pkg::STATUS_OK;
  endfunction

  function logic [prq_pkg::STATUS_W-1:0] remove_task(logic [prq_pkg::ID_W-1:0] id);
    int unsigned pos;
    pos = 0;
    while (pos < depth && slots[pos].id != id) pos++;
    if (pos >= depth) return prq_pkg::STATUS_NOT_FOUND;
    for (int unsigned k = pos; k + 1 < depth; k++) slots[k] = slots[k+1];
    depth--;
    return prq_pkg::STATUS_OK;
  endfunction

  // Apply one accepted item to the queue copy and record the result it owes.
  function void note_item(logic [prq_pkg::CMD_W-1:0] cmd, logic [prq_pkg::ID_W-1:0] id,
                          logic [prq_pkg::PRIO_W-1:0] prio, logic [prq_pkg::PRIO_W-1:0] ceil,
                          logic elev, logic [prq_pkg::DEADLINE_W-1:0] deadline);
    prq_pkg::prq_entry_t nw;
    head_report_t        want;
    nw.id = id;
    nw.prio = prio;
    nw.ceil = ceil;
    nw.elev = elev;
    nw.deadline = deadline;
    want.status = prq_pkg::STATUS_OK;
    case (cmd)
      prq_pkg::CMD_INSERT: begin
        want.status = insert_task(nw);
        inserts++;
        if (want.status == prq_pkg::STATUS_FULL) drops++;
      end
      prq_pkg::CMD_REMOVE: begin
        want.status = remove_task(id);
        removes++;
        if (want.status == prq_pkg::STATUS_NOT_FOUND) misses++;
      end
      default: begin
        queries++;
      end
    endcase
    if (depth > peak_depth) peak_depth = depth;
    want.head_valid = (depth > 0);
    want.head_id = (depth > 0) ? slots[0].id : '0;
    want.count = depth[prq_pkg::COUNT_W-1:0];
    owed_q.push_back(want);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH at result %0d: %s got %0h, expected %0h",
             results_seen, what, got, want);
  endtask

  // Compare one accepted result with the oldest owed one, field by field.
  task check_result(logic [prq_pkg::ID_W-1:0] id, logic hv,
                    logic [prq_pkg::COUNT_W-1:0] cnt, logic [prq_pkg::STATUS_W-1:0] st);
    head_report_t want;
    results_seen++;
    if (owed_q.size() == 0) begin
      report_mismatch("result with no item pending, head_task_id", 32'(id), 32'd0);
      return;
    end
    want = owed_q.pop_front();
    if (hv !== want.head_valid)
      report_mismatch("head_valid", 32'(hv), 32'(want.head_valid));
    if (id !== want.head_id)
      report_mismatch("head_task_id", 32'(id), 32'(want.head_id));
    if (cnt !== want.count)
      report_mismatch("entry_count", 32'(cnt), 32'(want.count));
    if (st !== want.status)
      report_mismatch("status", 32'(st), 32'(want.status));
  endtask

  function int unsigned owed();
    return owed_q.size();
  endfunction

  // Id of a task now held (any id when the queue is empty), so that most removes hit something.
  function logic [prq_pkg::ID_W-1:0] pick_stored_id();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (depth == 0) return r[prq_pkg::ID_W-1:0];
    return slots[$urandom_range(0, depth - 1)].id;
  endfunction

endclass

module priority_ready_queue_top_tb;
  import prq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PHASE_ITEMS = 634;
  localparam int unsigned TIDE_LEN    = 48;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Spare command code; the block treats it as a query.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command = CMD_QUERY;
  logic [ID_W-1:0]       task_id = '0;
  logic [PRIO_W-1:0]     priority_req = '0;
  logic [PRIO_W-1:0]     ceiling = '0;
  logic                  elevated = 1'b0;
  logic [DEADLINE_W-1:0] deadline = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ID_W-1:0]       head_task_id;
  logic                  head_valid;
  logic [COUNT_W-1:0]    entry_count;
  logic [STATUS_W-1:0]   status;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  prq_scoreboard #(QUEUE_DEPTH) sb;

  priority_ready_queue_top #(
    .MAX_TASKS(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .task_id(task_id),
    .priority_req(priority_req),
    .ceiling(ceiling),
    .elevated(elevated),
    .deadline(deadline),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head_task_id(head_task_id),
    .head_valid(head_valid),
    .entry_count(entry_count),
    .status(status)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watch both handshakes; values read here are those before the edge.
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (in_valid && in_ready)
        sb.note_item(command, task_id, priority_req, ceiling, elevated, deadline);
      if (out_valid && out_ready)
        sb.check_result(head_task_id, head_valid, entry_count, status);
    end
  end

  // Run time limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // Present one item and hold it until accepted. Valid stays high on return
  // so that a following item can go out without a gap.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input logic [PRIO_W-1:0] ceil,
                           input logic elev, input logic [DEADLINE_W-1:0] dl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    task_id <= id;
    priority_req <= prio;
    ceiling <= ceil;
    elevated <= elev;
    deadline <= dl;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender holds off until every owed result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.owed() != 0);
  endtask

  // Priority-like value: extremes, a narrow band that forces ties, or any.
  function automatic logic [PRIO_W-1:0] rand_level();
    int unsigned r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return PRIO_W'($urandom_range(0, 7));
    return PRIO_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [DEADLINE_W-1:0] rand_deadline();
    int unsigned r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return $urandom_range(0, 15);
    return $urandom();
  endfunction

  // One random item; the tide decides whether the queue tends to fill or drain.
  task automatic send_random_item(input bit filling);
    int unsigned       roll;
    int unsigned       ins_pct;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    ins_pct = filling ? 70 : 25;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) cmd = CMD_INSERT;
    else if (roll < 90) cmd = CMD_REMOVE;
    else if (roll < 96) cmd = CMD_QUERY;
    else cmd = CMD_SPARE;
    id = ID_W'($urandom_range(0, 15));
    if (cmd == CMD_REMOVE && $urandom_range(0, 99) < 75) id = sb.pick_stored_id();
    send_item(cmd, id, rand_level(), rand_level(), 1'($urandom_range(0, 1)),
              rand_deadline());
  endtask

  // Main sequence.
  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, single entry, fill to full with extreme fields.
    send_item(CMD_QUERY, 4'hF, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_REMOVE, 4'd5, 8'h00, 8'h00, 1'b0, 32'h0);
    send_item(CMD_INSERT, 4'd9, 8'hFF, 8'h00, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_REMOVE, 4'd9, 8'h12, 8'h34, 1'b1, 32'h5555_AAAA);
    send_item(CMD_INSERT, 4'd0, 8'h80, 8'h80, 1'b0, 32'h0000_1000);
    send_item(CMD_INSERT, 4'd1, 8'h80, 8'h80, 1'b0, 32'h0000_1000);
    send_item(CMD_INSERT, 4'd2, 8'h80, 8'h80, 1'b0, 32'h0000_0FFF);
    send_item(CMD_INSERT, 4'd3, 8'h00, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 4'd4, 8'hFF, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 4'd5, 8'h10, 8'h00, 1'b1, 32'h0000_0000);
    send_item(CMD_INSERT, 4'd6, 8'h00, 8'h00, 1'b0, 32'h0000_0000);
    send_item(CMD_INSERT, 4'd7, 8'h00, 8'h00, 1'b0, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 4'd8, 8'h7F, 8'hFE, 1'b1, 32'h8000_0000);
    send_item(CMD_INSERT, 4'd9, 8'hFE, 8'h7F, 1'b1, 32'h7FFF_FFFF);
    send_item(CMD_INSERT, 4'd10, 8'h40, 8'h40, 1'b1, 32'h0000_0040);
    send_item(CMD_INSERT, 4'd11, 8'hFF, 8'hFF, 1'b1, 32'h0000_0000);
    send_item(CMD_INSERT, 4'd12, 8'h01, 8'h02, 1'b0, 32'h0000_0001);
    send_item(CMD_INSERT, 4'd13, 8'hFF, 8'hFF, 1'b0, 32'hFFFF_FFFE);
    send_item(CMD_INSERT, 4'd14, 8'h55, 8'hAA, 1'b1, 32'hAAAA_5555);
    // A second task with id 3 makes the queue full; a remove takes the one nearer the head, the second.
    send_item(CMD_INSERT, 4'd3, 8'hAA, 8'h55, 1'b0, 32'h5555_AAAA);
    send_item(CMD_INSERT, 4'd15, 8'hFF, 8'hFF, 1'b1, 32'h0000_0000);
    send_item(CMD_REMOVE, 4'd3, 8'h00, 8'h00, 1'b0, 32'h0);
    send_item(CMD_REMOVE, 4'd15, 8'hFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_item(CMD_SPARE, 4'd7, 8'hC3, 8'h3C, 1'b1, 32'hDEAD_BEEF);
    hold_until_drained();

    // Random phases: sender-light idling, receiver-light idling, then none.
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int unsigned n = 0; n < PHASE_ITEMS; n++)
        send_random_item(((n / TIDE_LEN) % 2) == 0);
      hold_until_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d inserts (%0d dropped when full), %0d removes (%0d not found),",
             sb.inserts, sb.drops, sb.removes, sb.misses);
    $display("%0d queries, peak depth %0d, %0d results checked, %0d mismatches.",
             sb.queries, sb.peak_depth, sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
